### rtl/ssrb_pkg.sv
package ssrb_pkg;

  localparam int NUM_REGS_DEF = 5;
  localparam int DATA_W       = 8;
  localparam int CMD_ADDR_W   = 7;
  localparam int WR_ADDR_W    = 3;
  localparam int OUT_FIELDS_W = 21;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [DATA_W-1:0] REG1_INIT = 8'h32;
  localparam logic [DATA_W-1:0] REG4_INIT = 8'h55;

  // one-hot protocol phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_WDATA = 4'b0010,
    PH_SKIP1 = 4'b0100,
    PH_SKIP2 = 4'b1000
  } phase_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ssrb_ctl_t;

  // power-up contents of the bank; entries past the fifth start at zero
  function automatic logic [DATA_W-1:0] ssrb_init(input logic [CMD_ADDR_W-1:0] idx);
    logic [DATA_W-1:0] val;
    case (idx)
      7'd1:    val = REG1_INIT;
      7'd4:    val = REG4_INIT;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/ssrb_regfile.sv
module ssrb_regfile #(
  parameter int NUM_REGS = ssrb_pkg::NUM_REGS_DEF,
  parameter int AW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssrb_pkg::ssrb_ctl_t       ctl,
  input  logic [AW-1:0]             rd_addr,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ssrb_pkg::DATA_W-1:0] wr_data,
  output logic [ssrb_pkg::DATA_W-1:0] rd_data
);
  import ssrb_pkg::*;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [DATA_W-1:0]   rd_q_r;
  logic [DATA_W-1:0]   rd_init_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_init_r <= ssrb_init(CMD_ADDR_W'(rd_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // an entry never written reads as its power-up value
  assign rd_data = rd_vld_r ? rd_q_r : rd_init_r;

endmodule

### rtl/spi_slave_register_bank.sv
// Channel | Dir | Bits | Fields, lowest bit first
// in_*    | in  | 8    | rx_byte[7:0]
// out_*   | out | 24   | tx_load, tx_byte[8], write_done, write_addr[3], write_value[8], 3'b0
//
// One byte is accepted per cycle while in_tready is high; its result appears in
// the output register on the next cycle. The bank is read or written at most once
// per beat through one memory port pair, which sets the single-cycle rate.
// in_tready drops only while a result is held and out_tready is low.
// Reset (rst_n low, synchronous) returns to the idle phase and restores the
// power-up bank contents at once through per-entry valid bits.
module spi_slave_register_bank #(
  parameter int NUM_REGS = ssrb_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ssrb_pkg::DATA_W-1:0]    in_tdata,   // rx_byte[7:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tx_load[0], tx_byte[8:1], write_done[9], write_addr[12:10],
  // write_value[20:13], zero fill[23:21]
  output logic [ssrb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ssrb_pkg::*;

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  phase_t              phase_r, phase_nxt;
  logic [AW-1:0]       target_r, target_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                tx_load_r, inrange_r, wr_done_r;
  logic [WR_ADDR_W-1:0] wr_addr_r;
  logic [DATA_W-1:0]   wr_val_r;

  logic                in_fire;
  logic                is_wr_cmd;
  logic                addr_ok;
  logic [CMD_ADDR_W-1:0] cmd_addr;
  logic [AW-1:0]       cmd_idx;
  logic [DATA_W-1:0]   rd_data;
  logic [DATA_W-1:0]   tx_byte;
  ssrb_ctl_t           ctl;

  assign in_tready = !out_vld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_wr_cmd = in_tdata[DATA_W-1];
  assign cmd_addr  = in_tdata[CMD_ADDR_W-1:0];
  assign addr_ok   = (32'(cmd_addr) < NUM_REGS);
  assign cmd_idx   = addr_ok ? AW'(cmd_addr) : '0;

  assign ctl.rd_en = in_fire && (phase_r == PH_IDLE) && !is_wr_cmd;
  assign ctl.wr_en = in_fire && (phase_r == PH_WDATA);

  ssrb_regfile #(
    .NUM_REGS (NUM_REGS),
    .AW       (AW)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (cmd_idx),
    .wr_addr (target_r),
    .wr_data (in_tdata),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_nxt   = phase_r;
    target_nxt  = target_r;
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (in_fire) begin
      out_vld_nxt = 1'b1;
      case (phase_r)
        PH_IDLE: begin
          if (is_wr_cmd) begin
            target_nxt = cmd_idx;
            phase_nxt  = PH_WDATA;
          end else begin
            phase_nxt  = PH_SKIP1;
          end
        end
        PH_WDATA: phase_nxt = PH_IDLE;
        PH_SKIP1: phase_nxt = PH_SKIP2;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      target_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      target_r  <= target_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result fields; hold while the beat is stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_load_r <= ctl.rd_en;
      inrange_r <= addr_ok;
      wr_done_r <= ctl.wr_en;
      wr_addr_r <= ctl.wr_en ? WR_ADDR_W'(target_r) : '0;
      wr_val_r  <= ctl.wr_en ? in_tdata : '0;
    end
  end

  assign tx_byte    = (tx_load_r && inrange_r) ? rd_data : '0;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({wr_val_r, wr_addr_r, wr_done_r, tx_byte, tx_load_r});

endmodule

### rtl/ssrb_chk.sv
module ssrb_chk #(
  parameter int NUM_REGS = ssrb_pkg::NUM_REGS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ssrb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ssrb_pkg::*;

  logic tx_load, wr_done;
  assign tx_load = out_tdata[0];
  assign wr_done = out_tdata[9];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // input is only held off by a pending result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // an accepted input beat shows up as a result beat on the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(tx_load && wr_done) &&
                   (tx_load || out_tdata[8:1] == 8'd0) &&
                   (wr_done || out_tdata[20:10] == 11'd0) &&
                   out_tdata[23:21] == 3'd0)
    else $error("inactive result fields not zero");

  // a completed write names a register inside the bank
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && wr_done |-> (NUM_REGS > 8) ||
      (32'(out_tdata[12:10]) < NUM_REGS))
    else $error("write address out of range");

endmodule

bind spi_slave_register_bank ssrb_chk #(.NUM_REGS(NUM_REGS)) u_ssrb_chk (.*);
